// File: rtl/initrd_archive_header_parser_defines.svh
// Assertion macros shared by the archive header parser modules.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef INITRD_ARCHIVE_HEADER_PARSER_DEFINES_SVH
`define INITRD_ARCHIVE_HEADER_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define IAHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iahp: same-cycle check failed");
`define IAHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iahp: next-cycle check failed");
`else
`define IAHP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IAHP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/iahp_pkg.sv
package iahp_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int NAME_BYTES   = 32;
    localparam int SIZE_BYTES   = 4;
    localparam int HEADER_BYTES = NAME_BYTES + SIZE_BYTES;
    localparam int TABLE_BYTES  = MAX_ENTRIES * NAME_BYTES;

    localparam int POS_W   = $clog2(HEADER_BYTES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W  = $clog2(TABLE_BYTES);
    localparam int INDEX_W = 6;
    localparam int TOTAL_W = 7;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_SKIP   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        STOP_ZERO_NAME  = 2'd0,
        STOP_IMAGE_END  = 2'd1,
        STOP_TABLE_FULL = 2'd2,
        STOP_RUNNING    = 2'd3
    } stop_reason_t;

    typedef struct packed {
        logic               recorded;
        logic [INDEX_W-1:0] index;
        logic [31:0]        size;
        logic [31:0]        offset;
        logic               finished;
        stop_reason_t       reason;
        logic [TOTAL_W-1:0] total;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } name_wr_t;

endpackage

// File: rtl/iahp_name_ram.sv
module iahp_name_ram #(
    parameter int DEPTH  = 2048,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

endmodule

// File: rtl/iahp_parser.sv
`include "initrd_archive_header_parser_defines.svh"

module iahp_parser
    import iahp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic [7:0] data_byte,
    input  logic     first_byte,
    input  logic     end_of_image,
    output logic     res_valid,
    output result_t  res,
    output name_wr_t name_wr
);

    phase_t           phase_reg, phase_next, phase_eff;
    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [31:0]      size_reg, size_next, size_eff, size_full;
    logic [31:0]      skip_reg, skip_next, skip_eff, skip_dec;
    logic [31:0]      offset_reg, offset_next, offset_eff;
    logic [CNT_W-1:0] count_reg, count_next, count_eff;
    logic             active;
    logic [1:0]       lane;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            size_reg   <= '0;
            skip_reg   <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            size_reg   <= size_next;
            skip_reg   <= skip_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
        end
    end

    // A first byte restarts the parse; otherwise a running parse advances the offset.
    always_comb
    begin
        phase_eff  = phase_reg;
        pos_eff    = pos_reg;
        size_eff   = size_reg;
        skip_eff   = skip_reg;
        offset_eff = offset_reg;
        count_eff  = count_reg;
        active     = 1'b0;
        if (first_byte)
        begin
            phase_eff  = PH_HEADER;
            pos_eff    = '0;
            size_eff   = '0;
            skip_eff   = '0;
            offset_eff = '0;
            count_eff  = '0;
            active     = 1'b1;
        end
        else if (phase_reg != PH_IDLE)
        begin
            offset_eff = offset_reg + 32'd1;
            active     = 1'b1;
        end
    end

    assign skip_dec = skip_eff - 32'd1;
    assign lane     = 2'(pos_eff - POS_W'(NAME_BYTES));

    always_comb
    begin
        size_full = size_eff;
        if (pos_eff >= POS_W'(NAME_BYTES))
        begin
            size_full[8*lane +: 8] = data_byte;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        size_next     = size_reg;
        skip_next     = skip_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        res_valid     = 1'b0;
        res           = '0;
        name_wr.en    = 1'b0;
        name_wr.addr  = ADDR_W'(ADDR_W'(count_eff) * ADDR_W'(NAME_BYTES)) + ADDR_W'(pos_eff);
        name_wr.data  = (pos_eff == POS_W'(NAME_BYTES - 1)) ? 8'd0 : data_byte;
        if (accept && active)
        begin
            phase_next  = phase_eff;
            pos_next    = pos_eff;
            size_next   = size_eff;
            skip_next   = skip_eff;
            offset_next = offset_eff;
            count_next  = count_eff;
            unique case (phase_eff)
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                        size_next  = '0;
                    end
                    if (end_of_image)
                    begin
                        phase_next   = PH_IDLE;
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                        res.reason   = STOP_IMAGE_END;
                    end
                end
                PH_HEADER:
                begin
                    if (pos_eff == '0 && data_byte == 8'd0)
                    begin
                        phase_next   = PH_IDLE;
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                        res.reason   = STOP_ZERO_NAME;
                    end
                    else if (pos_eff == POS_W'(HEADER_BYTES - 1))
                    begin
                        count_next   = count_eff + CNT_W'(1);
                        pos_next     = '0;
                        size_next    = '0;
                        skip_next    = size_full;
                        phase_next   = (size_full != 32'd0) ? PH_SKIP : PH_HEADER;
                        res_valid    = 1'b1;
                        res.recorded = 1'b1;
                        res.index    = INDEX_W'(count_eff);
                        res.size     = size_full;
                        res.offset   = offset_eff + 32'd1;
                        res.reason   = STOP_RUNNING;
                        if (end_of_image)
                        begin
                            phase_next   = PH_IDLE;
                            res.finished = 1'b1;
                            res.reason   = STOP_IMAGE_END;
                        end
                        else if (count_eff == CNT_W'(MAX_ENTRIES - 1))
                        begin
                            phase_next   = PH_IDLE;
                            res.finished = 1'b1;
                            res.reason   = STOP_TABLE_FULL;
                        end
                    end
                    else
                    begin
                        name_wr.en = (pos_eff < POS_W'(NAME_BYTES));
                        size_next  = size_full;
                        pos_next   = pos_eff + POS_W'(1);
                        if (end_of_image)
                        begin
                            phase_next   = PH_IDLE;
                            res_valid    = 1'b1;
                            res.finished = 1'b1;
                            res.reason   = STOP_IMAGE_END;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            res.total = TOTAL_W'(count_next);
        end
    end

    `IAHP_ASSERT_IMP(a_skip_nonzero, clk, rst_n, (phase_reg == PH_SKIP), (skip_reg != 32'd0))
    `IAHP_ASSERT_IMP(a_count_room, clk, rst_n, (phase_reg != PH_IDLE), (count_reg < CNT_W'(MAX_ENTRIES)))
    `IAHP_ASSERT_IMP(a_pos_range, clk, rst_n, (phase_reg == PH_HEADER), (pos_reg < POS_W'(HEADER_BYTES)))

endmodule

// File: rtl/iahp_out_buf.sv
`include "initrd_archive_header_parser_defines.svh"

module iahp_out_buf
    import iahp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            out_reg        <= out_next;
            skid_reg       <= skid_next;
        end
    end

    `IAHP_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `IAHP_ASSERT_NXT(a_stall_to_skid, clk, rst_n, (push && out_valid_reg && !out_ready), skid_valid_reg)
    `IAHP_ASSERT_NXT(a_skid_drains, clk, rst_n, (skid_valid_reg && pop), (out_valid_reg && !skid_valid_reg))

endmodule

// File: rtl/initrd_archive_header_parser.sv
// Archive header parser. The block takes an archive image one byte per
// transaction and walks its entries: a 32-byte name, a 4-byte little-endian
// size and then that many data bytes, which are skipped. Name bytes are
// written into the entry's slot of an on-chip name table (byte 31 of each
// name is stored as zero); the table is a single-port synchronous memory of
// 64 slots by 32 bytes that takes one write per cycle and needs no clearing
// after reset. A result transaction is produced only when a byte completes
// an entry header (index, size, offset of the first data byte, running
// total) or when parsing stops: on a zero first name byte, on the byte
// flagged as the end of the image, or once the table is full. A byte with
// first_byte set restarts the parse from any state; bytes arriving while the
// parser is stopped and without that flag are consumed and produce nothing.
// Throughput is one byte per clock cycle while in_ready is high, limited
// only by the single register update of the parse state and the one table
// write per byte. Each result is registered in the output buffer. The
// output side holds up to two results, so in_ready stays high while one
// result waits and drops only when both entries are occupied.
module initrd_archive_header_parser
    import iahp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        end_of_image,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        entry_recorded,
    output logic [5:0]  entry_index,
    output logic [31:0] file_size,
    output logic [31:0] data_offset,
    output logic        finished,
    output logic [1:0]  stop_reason,
    output logic [6:0]  entry_total
);

    logic     accept;
    logic     res_valid;
    result_t  res;
    result_t  out_data;
    name_wr_t name_wr;

    // A byte is taken whenever the output side has room for one more result.
    assign accept = in_valid && in_ready;

    // Parse state machine: phase, header position, size assembly, skip count,
    // offset and entry count, updated once per accepted byte.
    iahp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .end_of_image (end_of_image),
        .res_valid    (res_valid),
        .res          (res),
        .name_wr      (name_wr)
    );

    // The name table. It has no read port; its contents never feed the results.
    iahp_name_ram #(
        .DEPTH  (TABLE_BYTES),
        .WIDTH  (8),
        .ADDR_W (ADDR_W)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_wr.en),
        .addr  (name_wr.addr),
        .wdata (name_wr.data)
    );

    // Output register with a skid entry behind it.
    iahp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign entry_recorded = out_data.recorded;
    assign entry_index    = out_data.index;
    assign file_size      = out_data.size;
    assign data_offset    = out_data.offset;
    assign finished       = out_data.finished;
    assign stop_reason    = out_data.reason;
    assign entry_total    = out_data.total;

endmodule
